// ===== rtl/csrmv_pkg.sv =====
// Shared types and constants of the compressed-row sparse matrix-vector product block.
// Holds function and status codes, the controller command and status structs, and helpers.
// Depends on nothing.
package csrmv_pkg;

   localparam int unsigned FuncW = 3;
   localparam int unsigned IdxW = 6;
   localparam int unsigned DataW = 32;
   localparam int unsigned DimW = 7;
   localparam int unsigned VecDepth = 64;
   localparam int unsigned OutCap = 64;
   localparam int unsigned AccW = 80;

   localparam logic [FuncW-1:0] FUNC_ADD = 3'd0;
   localparam logic [FuncW-1:0] FUNC_CLOSE = 3'd1;
   localparam logic [FuncW-1:0] FUNC_LOAD = 3'd2;
   localparam logic [FuncW-1:0] FUNC_FWD = 3'd3;
   localparam logic [FuncW-1:0] FUNC_TRN = 3'd4;

   localparam logic [2:0] ST_OK = 3'd0;
   localparam logic [2:0] ST_BAD_COL = 3'd1;
   localparam logic [2:0] ST_ROWS = 3'd2;
   localparam logic [2:0] ST_FULL = 3'd3;
   localparam logic [2:0] ST_MISSING = 3'd4;

   localparam logic REG_ROWS = 1'b0;
   localparam logic REG_COLS = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_acc;        // zero the running row sum
      logic mac;              // multiply-accumulate the entry read last cycle
      logic trn_mode;         // add into the column sum table instead of the row sum
      logic load_out;         // load a finished sum into the output register
      logic out_from_table;   // take the sum from the column table
      logic [IdxW-1:0] out_index;
      logic out_last;
      logic [IdxW-1:0] tbl_addr; // column sum table address for clear or readout
      logic tbl_clear;
      logic tbl_read;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic out_full;
   } dp_sts_type;

   // Truncate toward zero from Q48.32 to Q16.16 and saturate.
   function automatic logic [DataW-1:0] to_q16(input logic [AccW-1:0] acc);
      logic neg;
      logic [AccW-1:0] mag;
      logic [AccW-17:0] q;
      neg = acc[AccW-1];
      mag = neg ? (~acc + AccW'(1)) : acc;
      q = mag[AccW-1:16];
      if (neg) begin
         if (q > (AccW-16)'(32'h8000_0000)) to_q16 = 32'h8000_0000;
         else to_q16 = 32'(~q[31:0] + 32'd1);
      end else begin
         if (q > (AccW-16)'(32'h7FFF_FFFF)) to_q16 = 32'h7FFF_FFFF;
         else to_q16 = q[31:0];
      end
   endfunction

endpackage

// ===== rtl/csrmv_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// Depends on nothing.
module csrmv_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/csrmv_datapath.sv =====
// Datapath: multiply-accumulate, column sum table, output register.
// Depends on csrmv_pkg and csrmv_ram.
module csrmv_datapath (
   input  logic                        clock,
   input  logic                        reset,
   input  csrmv_pkg::dp_cmd_type       cmd,
   output csrmv_pkg::dp_sts_type       sts,
   // operands from memories, already registered
   input  logic [csrmv_pkg::DataW-1:0] op_a,
   input  logic [csrmv_pkg::DataW-1:0] op_b,
   input  logic [csrmv_pkg::IdxW-1:0]  op_col,
   // single-result path
   input  logic                        single_load,
   input  logic [2:0]                  single_status,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [2:0]                  rsp_status,
   output logic [csrmv_pkg::IdxW-1:0]  rsp_index,
   output logic [csrmv_pkg::DataW-1:0] rsp_value,
   output logic                        rsp_last
);
   localparam int unsigned AccW = csrmv_pkg::AccW;
   localparam int unsigned IdxW = csrmv_pkg::IdxW;

   logic signed [63:0] prod_ff;
   logic prod_v_ff, prod_trn_ff;
   logic [IdxW-1:0] prod_col_ff;
   logic [AccW-1:0] acc_ff;
   logic tbl_we;
   logic [IdxW-1:0] tbl_wa, tbl_ra;
   logic [AccW-1:0] tbl_wd, tbl_rd;
   // read-modify-write hazard: last written column sum held for forwarding
   logic [IdxW-1:0] fwd_col_ff;
   logic fwd_v_ff;
   logic [AccW-1:0] fwd_val_ff;
   logic [AccW-1:0] base;
   logic rd_cmd_ff;
   logic [IdxW-1:0] rd_idx_ff;
   logic rd_last_ff;
   logic out_v_ff;

   // stage 1: multiply, and start the column sum read
   always_ff @(posedge clock) begin
      prod_ff <= $signed(op_a) * $signed(op_b);
      prod_col_ff <= op_col;
      if (reset) begin
         prod_v_ff <= 1'b0;
         prod_trn_ff <= 1'b0;
      end else begin
         prod_v_ff <= cmd.mac;
         prod_trn_ff <= cmd.trn_mode;
      end
   end

   // table read address: pending column during accumulation, else readout address
   assign tbl_ra = cmd.mac ? op_col : cmd.tbl_addr;
   assign base = (fwd_v_ff && fwd_col_ff == prod_col_ff) ? fwd_val_ff : tbl_rd;
   assign tbl_we = cmd.tbl_clear || (prod_v_ff && prod_trn_ff);
   assign tbl_wa = cmd.tbl_clear ? cmd.tbl_addr : prod_col_ff;
   assign tbl_wd = cmd.tbl_clear ? '0 : base + AccW'(prod_ff);

   csrmv_ram #(.WIDTH(AccW), .DEPTH(csrmv_pkg::OutCap)) u_tbl (
      .clock(clock), .wr_en(tbl_we), .wr_addr(tbl_wa), .wr_data(tbl_wd),
      .rd_addr(tbl_ra), .rd_data(tbl_rd)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fwd_v_ff <= 1'b0;
         rd_cmd_ff <= 1'b0;
         out_v_ff <= 1'b0;
      end else begin
         fwd_v_ff <= tbl_we && !cmd.tbl_clear;
         rd_cmd_ff <= cmd.tbl_read;
         // set on a new load, hold until the transfer completes
         out_v_ff <= single_load || rd_cmd_ff || (cmd.load_out && !cmd.out_from_table)
            || (out_v_ff && !rsp_tready);
      end
      fwd_col_ff <= tbl_wa;
      fwd_val_ff <= tbl_wd;
      rd_idx_ff <= cmd.out_index;
      rd_last_ff <= cmd.out_last;
      if (cmd.clear_acc) acc_ff <= '0;
      else if (prod_v_ff && !prod_trn_ff) acc_ff <= acc_ff + AccW'(prod_ff);
      if (single_load) begin
         rsp_status <= single_status;
         rsp_index <= '0;
         rsp_value <= '0;
         rsp_last <= 1'b1;
      end else if (rd_cmd_ff) begin
         rsp_status <= csrmv_pkg::ST_OK;
         rsp_index <= rd_idx_ff;
         rsp_value <= csrmv_pkg::to_q16(tbl_rd);
         rsp_last <= rd_last_ff;
      end else if (cmd.load_out && !cmd.out_from_table) begin
         rsp_status <= csrmv_pkg::ST_OK;
         rsp_index <= cmd.out_index;
         rsp_value <= csrmv_pkg::to_q16(acc_ff);
         rsp_last <= cmd.out_last;
      end
   end

   assign rsp_tvalid = out_v_ff;
   assign sts.out_full = out_v_ff && !rsp_tready;
endmodule

// ===== rtl/csrmv_ctrl.sv =====
// Controller: decodes items, keeps the matrix build state, sequences products.
// Depends on csrmv_pkg and csrmv_ram.
module csrmv_ctrl #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [2:0]                  req_func,
   input  logic [5:0]                  req_column,
   input  logic [31:0]                 req_weight,
   input  logic [5:0]                  req_index,
   input  logic [31:0]                 req_value,
   input  logic                        cfg_we,
   input  logic                        cfg_addr,
   input  logic [6:0]                  cfg_data,
   output logic [6:0]                  num_rows,
   output logic [6:0]                  num_cols,
   output csrmv_pkg::dp_cmd_type       cmd,
   input  csrmv_pkg::dp_sts_type       sts,
   input  logic                        out_busy,
   output logic [31:0]                 op_a,
   output logic [31:0]                 op_b,
   output logic [5:0]                  op_col,
   output logic                        single_load,
   output logic [2:0]                  single_status
);
   localparam int unsigned RowCap = (MAX_ROWS < 64) ? MAX_ROWS : 64;
   localparam int unsigned ColCap = (MAX_COLS < 64) ? MAX_COLS : 64;
   localparam int unsigned EW = $clog2(MAX_ENTRIES + 1);
   localparam int unsigned EA = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned RA = $clog2(RowCap + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_RS0, S_RS1, S_RUN, S_DRAIN, S_EMIT, S_CLR, S_TOUT, S_WAIT
   } state_type;

   state_type state_ff;
   logic [6:0] rows_ff, cols_ff, rows_closed_ff;
   logic [EW-1:0] count_ff;
   logic trn_ff;
   logic [6:0] r_ff;              // current row, table clear address or readout column
   logic [EW-1:0] e_ff, e_end_ff;
   logic [2:0] drain_ff;
   logic accept;
   logic [EW-1:0] rs_rd;
   logic [RA-1:0] rs_ra;
   logic [5:0] ecol_rd;
   logic [31:0] ew_rd, vec_rd, y_ff;
   logic [5:0] vec_ra;
   logic ent_we, mac_ff;
   logic [6:0] clamp;
   logic rd_ff;                   // column table read issued last cycle

   function automatic logic [6:0] clamp_dim(input logic [6:0] v, input int unsigned cap);
      logic [6:0] d;
      d = (v == 7'd0) ? 7'd1 : v;
      if (32'(d) > cap) d = 7'(cap);
      return d;
   endfunction

   assign clamp = cfg_data;
   assign num_rows = rows_ff;
   assign num_cols = cols_ff;
   // accept only in idle; hold the input while the output is busy or a result is on its way to it
   assign req_tready = (state_ff == S_IDLE) && !out_busy && !single_load && !rd_ff;
   assign accept = req_tvalid && req_tready;

   assign ent_we = accept && req_func == csrmv_pkg::FUNC_ADD && rows_closed_ff < rows_ff
      && 7'(req_column) < cols_ff
      && req_weight != '0 && 32'(count_ff) < MAX_ENTRIES;

   csrmv_ram #(.WIDTH(6), .DEPTH(MAX_ENTRIES)) u_ecol (
      .clock(clock), .wr_en(ent_we), .wr_addr(EA'(count_ff)), .wr_data(req_column),
      .rd_addr(EA'(e_ff)), .rd_data(ecol_rd));
   csrmv_ram #(.WIDTH(32), .DEPTH(MAX_ENTRIES)) u_ew (
      .clock(clock), .wr_en(ent_we), .wr_addr(EA'(count_ff)), .wr_data(req_weight),
      .rd_addr(EA'(e_ff)), .rd_data(ew_rd));
   csrmv_ram #(.WIDTH(EW), .DEPTH(RowCap + 1)) u_rs (
      .clock(clock),
      .wr_en(accept && req_func == csrmv_pkg::FUNC_CLOSE && rows_closed_ff < rows_ff),
      .wr_addr(RA'(rows_closed_ff + 7'd1)), .wr_data(count_ff),
      .rd_addr(rs_ra), .rd_data(rs_rd));

   // the forward product reads x at the entry column, the transpose reads y at the row
   assign vec_ra = (state_ff == S_RS0) ? r_ff[5:0] : ecol_rd;
   csrmv_ram #(.WIDTH(32), .DEPTH(csrmv_pkg::VecDepth)) u_vec (
      .clock(clock), .wr_en(accept && req_func == csrmv_pkg::FUNC_LOAD),
      .wr_addr(req_index), .wr_data(req_value), .rd_addr(vec_ra), .rd_data(vec_rd));

   assign rs_ra = (state_ff == S_RS0) ? RA'(r_ff) : RA'(r_ff + 7'd1);

   // entry pipeline: e_ff addresses column and weight, then the registered column addresses the vector
   logic mac1_ff;
   logic [31:0] ew2_ff;
   logic [5:0] col2_ff;
   always_ff @(posedge clock) begin
      ew2_ff <= ew_rd;
      col2_ff <= ecol_rd;
   end
   assign op_a = ew2_ff;
   assign op_b = trn_ff ? y_ff : vec_rd;
   assign op_col = col2_ff;

   always_comb begin
      cmd = '0;
      cmd.trn_mode = trn_ff;
      cmd.mac = mac1_ff;
      cmd.clear_acc = (state_ff == S_RS1);
      cmd.load_out = (state_ff == S_EMIT) && !sts.out_full;
      cmd.out_index = r_ff[5:0];
      cmd.out_last = (trn_ff ? (r_ff + 7'd1 == cols_ff) : (r_ff + 7'd1 == rows_ff));
      cmd.tbl_clear = (state_ff == S_CLR);
      cmd.tbl_addr = r_ff[5:0];
      cmd.tbl_read = (state_ff == S_TOUT) && !out_busy && !rd_ff;
      cmd.out_from_table = trn_ff;
      if (state_ff == S_TOUT) cmd.mac = 1'b0;
   end

   always_ff @(posedge clock) begin
      single_load <= 1'b0;
      mac_ff <= 1'b0;
      mac1_ff <= mac_ff && (ecol_rd < 6'(ColCap - 1) || 32'(ecol_rd) < ColCap || !trn_ff);
      if (state_ff == S_RS1 || state_ff == S_RS0) y_ff <= vec_rd;
      if (reset) begin
         state_ff <= S_IDLE;
         rows_ff <= 7'(RowCap);
         cols_ff <= 7'(ColCap);
         rows_closed_ff <= '0;
         count_ff <= '0;
         trn_ff <= 1'b0;
         rd_ff <= 1'b0;
         r_ff <= '0;
      end else begin
         rd_ff <= cmd.tbl_read;
         if (cfg_we) begin
            if (cfg_addr == csrmv_pkg::REG_ROWS) rows_ff <= clamp_dim(clamp, RowCap);
            else cols_ff <= clamp_dim(clamp, ColCap);
            rows_closed_ff <= '0;
            count_ff <= '0;
         end
         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  single_load <= 1'b1;
                  single_status <= csrmv_pkg::ST_OK;
                  case (req_func)
                     csrmv_pkg::FUNC_ADD: begin
                        if (rows_closed_ff >= rows_ff) single_status <= csrmv_pkg::ST_ROWS;
                        else if (7'(req_column) >= cols_ff)
                           single_status <= csrmv_pkg::ST_BAD_COL;
                        else if (req_weight == '0) single_status <= csrmv_pkg::ST_OK;
                        else if (32'(count_ff) >= MAX_ENTRIES)
                           single_status <= csrmv_pkg::ST_FULL;
                        else count_ff <= count_ff + EW'(1);
                     end
                     csrmv_pkg::FUNC_CLOSE: begin
                        if (rows_closed_ff >= rows_ff) single_status <= csrmv_pkg::ST_ROWS;
                        else rows_closed_ff <= rows_closed_ff + 7'd1;
                     end
                     csrmv_pkg::FUNC_LOAD: ;
                     csrmv_pkg::FUNC_FWD, csrmv_pkg::FUNC_TRN: begin
                        if (rows_closed_ff != rows_ff) begin
                           single_status <= csrmv_pkg::ST_MISSING;
                        end else begin
                           single_load <= 1'b0;
                           trn_ff <= (req_func == csrmv_pkg::FUNC_TRN);
                           r_ff <= '0;
                           state_ff <= (req_func == csrmv_pkg::FUNC_TRN) ? S_CLR : S_RS0;
                        end
                     end
                     default: single_load <= 1'b0;
                  endcase
               end
            end
            S_CLR: begin
               r_ff <= r_ff + 7'd1;
               if (r_ff == 7'(ColCap - 1)) begin
                  r_ff <= '0;
                  state_ff <= S_RS0;
               end
            end
            S_RS0: state_ff <= S_RS1;  // row_start[r] arriving
            S_RS1: begin
               e_ff <= (r_ff == 7'd0) ? '0 : rs_rd;
               state_ff <= S_WAIT;
            end
            S_WAIT: begin
               e_end_ff <= rs_rd;
               state_ff <= S_RUN;
            end
            S_RUN: begin
               if (e_ff < e_end_ff && 32'(e_ff) < MAX_ENTRIES) begin
                  mac_ff <= 1'b1;
                  e_ff <= e_ff + EW'(1);
               end else begin
                  drain_ff <= 3'd4;
                  state_ff <= S_DRAIN;
               end
            end
            S_DRAIN: begin
               drain_ff <= drain_ff - 3'd1;
               if (drain_ff == 3'd0) begin
                  if (trn_ff) begin
                     if (r_ff + 7'd1 == rows_ff) begin
                        r_ff <= '0;
                        state_ff <= S_TOUT;
                     end else begin
                        r_ff <= r_ff + 7'd1;
                        state_ff <= S_RS0;
                     end
                  end else state_ff <= S_EMIT;
               end
            end
            S_EMIT: begin
               if (!sts.out_full) begin
                  if (r_ff + 7'd1 == rows_ff) state_ff <= S_IDLE;
                  else begin
                     r_ff <= r_ff + 7'd1;
                     state_ff <= S_RS0;
                  end
               end
            end
            S_TOUT: begin
               if (cmd.tbl_read) begin
                  if (r_ff + 7'd1 == cols_ff) state_ff <= S_IDLE;
                  else r_ff <= r_ff + 7'd1;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

// ===== rtl/csr_sparse_matrix_vector_product.sv =====
// Top level of the compressed-row sparse matrix-vector product block.
// Joins the controller, the datapath and the configuration registers.
// Depends on csrmv_pkg, csrmv_ctrl, csrmv_datapath and csrmv_ram.
//
// Usage:
//   req_* carries one command per transfer: add entry, close row, load a
//   vector element, forward product A*x, or transpose product A^T*y.
//   rsp_* returns results: one per build or load command, num_rows results
//   for a forward product, num_cols results for a transpose product; tlast
//   marks the final one. csr_* is an APB-style port for num_rows (0x0) and
//   num_cols (0x4); a write restarts the matrix build and keeps the vector.
// Sequence:
//   A build or load command is taken in, its status registered, then loaded
//   into the result register and sent; the next command waits until that
//   register is free. A forward product reads each row's bounds, walks its
//   entries, drains the pipeline and emits the row sum. A transpose product
//   clears the column-sum table, walks each row adding into the column sums,
//   then reads out each column sum, all on one multiply-accumulate unit.
// Reset clears the build state and sets the dimensions to MAX_ROWS and MAX_COLS
// (at most 64); stored entries and the vector stay undefined until written. A stalled
// receiver holds the result register and the controller waits; no result is lost.
module csr_sparse_matrix_vector_product #(
   parameter int unsigned MAX_ROWS = 64,
   parameter int unsigned MAX_COLS = 64,
   parameter int unsigned MAX_ENTRIES = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [2:0] func, [8:3] column, [40:9] weight, [46:41] index, [78:47] value, zero pad
   input  logic [79:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [2:0] status, [8:3] out_index, [40:9] out_value, zero pad
   output logic [47:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   csrmv_pkg::dp_cmd_type cmd;
   csrmv_pkg::dp_sts_type sts;
   logic [6:0] num_rows, num_cols;
   logic [31:0] op_a, op_b;
   logic [5:0] op_col;
   logic single_load;
   logic [2:0] single_status, rsp_status;
   logic [5:0] rsp_index;
   logic [31:0] rsp_value;
   logic cfg_we;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite && (csr_paddr[2] == 1'b0 ||
      csr_paddr == 3'd4);
   assign csr_prdata = (csr_paddr == 3'd0) ? {25'd0, num_rows} :
      (csr_paddr == 3'd4) ? {25'd0, num_cols} : 32'd0;

   csrmv_ctrl #(.MAX_ROWS(MAX_ROWS), .MAX_COLS(MAX_COLS), .MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_func(req_tdata[2:0]), .req_column(req_tdata[8:3]),
      .req_weight(req_tdata[40:9]), .req_index(req_tdata[46:41]),
      .req_value(req_tdata[78:47]),
      .cfg_we(cfg_we && csr_paddr[1:0] == 2'd0 && csr_paddr != 3'd3),
      .cfg_addr(csr_paddr[2]), .cfg_data(csr_pwdata[6:0]),
      .num_rows(num_rows), .num_cols(num_cols),
      .cmd(cmd), .sts(sts), .out_busy(rsp_tvalid),
      .op_a(op_a), .op_b(op_b), .op_col(op_col),
      .single_load(single_load), .single_status(single_status));

   csrmv_datapath u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .op_a(op_a), .op_b(op_b), .op_col(op_col),
      .single_load(single_load), .single_status(single_status),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_status(rsp_status), .rsp_index(rsp_index),
      .rsp_value(rsp_value), .rsp_last(rsp_tlast));

   assign rsp_tdata = {7'd0, rsp_value, rsp_index, rsp_status};
endmodule
